### hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the printer control code parser.
// Depends on nothing; define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks that the consequent follows the antecedent on the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds at the edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### hw/rtl/pcp_pkg.sv
// Types, codes and helper functions of the printer control code parser.
// Used by pcp_decode and printer_control_code_parser; depends on nothing.
package pcp_pkg;

    localparam int CHAR_W = 21;

    // Printer actions.
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_APPEND  = 3'd1;
    localparam logic [2:0] ACT_NEWLINE = 3'd2;
    localparam logic [2:0] ACT_CR      = 3'd3;
    localparam logic [2:0] ACT_LF      = 3'd4;
    localparam logic [2:0] ACT_PAGE    = 3'd5;
    localparam logic [2:0] ACT_FONT    = 3'd6;

    // Font width codes.
    localparam logic [1:0] FONT_NORMAL    = 2'd0;
    localparam logic [1:0] FONT_EXPANDED  = 2'd1;
    localparam logic [1:0] FONT_CONDENSED = 2'd2;

    // Dialects.
    localparam logic [1:0] MODE_SIMPLE = 2'd0;
    localparam logic [1:0] MODE_CRLF   = 2'd1;
    localparam logic [1:0] MODE_DOT    = 2'd2;

    // Character codes with a meaning.
    localparam logic [CHAR_W-1:0] CH_LF        = 21'h0A;
    localparam logic [CHAR_W-1:0] CH_FF        = 21'h0C;
    localparam logic [CHAR_W-1:0] CH_CR        = 21'h0D;
    localparam logic [CHAR_W-1:0] CH_EXPAND    = 21'h0E;
    localparam logic [CHAR_W-1:0] CH_CONDENSE  = 21'h0F;
    localparam logic [CHAR_W-1:0] CH_CANCEL_CD = 21'h12;
    localparam logic [CHAR_W-1:0] CH_CANCEL_EX = 21'h14;
    localparam logic [CHAR_W-1:0] CH_ESC       = 21'h1B;
    localparam logic [CHAR_W-1:0] CH_UNDERLINE = 21'h2D;
    localparam logic [CHAR_W-1:0] CH_C0_LAST   = 21'h1F;
    localparam logic [CHAR_W-1:0] CH_C1_FIRST  = 21'h7F;
    localparam logic [CHAR_W-1:0] CH_C1_LAST   = 21'h9F;

    typedef struct packed {
        logic       escape;
        logic       underline_arg;
        logic [1:0] font;
    } pcp_state_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [CHAR_W-1:0] out_char;
        logic              font_changed;
        logic [1:0]        font_width;
        logic              unknown_code;
    } pcp_result_t;

    // Control characters are the C0 range and the DEL plus C1 range.
    function automatic logic is_control(input logic [CHAR_W-1:0] c);
        return (c <= CH_C0_LAST) || ((c >= CH_C1_FIRST) && (c <= CH_C1_LAST));
    endfunction

endpackage

### hw/rtl/printer_control_code_parser.sv
// Top level of the printer control code parser: input register, decode, result register.
// Depends on pcp_pkg, pcp_decode and assert_macros.svh.
//
//  Channel   Handshake                   Payload
//  -------   -------------------------   ---------------------------------------------
//  char      char_valid / char_stall     char_code
//  result    result_valid / result_stall action, out_char, font_changed, font_width,
//                                        unknown_code
//  config    dialect_mode_we             dialect_mode_wdata
//
// One character is taken per cycle while the result side does not stall. A transfer
// on the char channel lands in the input register; from there it is decoded against
// the parser state and loaded into the result register, which drives the outputs.
// Reset clears the dialect to simple, the escape and underline state, the font to
// normal and both valid flags. A stall on the result side holds the result register
// and, once the input register is also full, raises char_stall in the same cycle.
module printer_control_code_parser (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         char_valid,
    output logic                         char_stall,
    input  logic [pcp_pkg::CHAR_W-1:0]   char_code,

    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [2:0]                   action,
    output logic [pcp_pkg::CHAR_W-1:0]   out_char,
    output logic                         font_changed,
    output logic [1:0]                   font_width,
    output logic                         unknown_code,

    input  logic                         dialect_mode_we,
    input  logic [1:0]                   dialect_mode_wdata
);

`include "assert_macros.svh"

    // Configuration and parser state.
    logic [1:0]              mode_reg;
    pcp_pkg::pcp_state_t     state_reg;
    pcp_pkg::pcp_state_t     state_next;

    // Input register.
    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic [pcp_pkg::CHAR_W-1:0]  in_char_reg;

    // Result register.
    logic                    out_valid_reg;
    logic                    out_valid_next;
    pcp_pkg::pcp_result_t    out_reg;
    pcp_pkg::pcp_result_t    dec_result;

    logic char_xfer;
    logic advance;

    // The input register moves on whenever the result register is free or
    // being emptied in this cycle.
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign char_stall = in_valid_reg && !advance;
    assign char_xfer  = char_valid && !char_stall;

    always_comb
    begin
        if (char_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    pcp_decode u_decode (
        .mode       (mode_reg),
        .char_code  (in_char_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (dec_result)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= pcp_pkg::MODE_SIMPLE;
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (dialect_mode_we)
            begin
                mode_reg <= dialect_mode_wdata;
            end
            // The state only moves when a character is actually decoded.
            if (advance)
            begin
                state_reg <= state_next;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (char_xfer)
        begin
            in_char_reg <= char_code;
        end
        if (advance)
        begin
            out_reg <= dec_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign action       = out_reg.action;
    assign out_char     = out_reg.out_char;
    assign font_changed = out_reg.font_changed;
    assign font_width   = out_reg.font_width;
    assign unknown_code = out_reg.unknown_code;

    // The underline argument can only be awaited inside an escape sequence.
    `ASSERT_IMPLY(a_arg_in_escape, clk, rst_n, state_reg.underline_arg, state_reg.escape, "underline wait outside escape")
    // An accepted character always lands in the input register.
    `ASSERT_NEXT(a_xfer_loads, clk, rst_n, char_xfer, in_valid_reg, "accepted character lost")
    // Only an append carries a character.
    `ASSERT_IMPLY(a_char_on_append, clk, rst_n, out_valid_reg && (out_reg.action != pcp_pkg::ACT_APPEND), out_reg.out_char == '0, "character on a non-append result")
    // A font change comes only with a font code or a line feed.
    `ASSERT_IMPLY(a_font_change_kind, clk, rst_n, out_valid_reg && out_reg.font_changed, (out_reg.action == pcp_pkg::ACT_FONT) || (out_reg.action == pcp_pkg::ACT_LF), "font change on wrong action")

endmodule

### hw/rtl/pcp_decode.sv
// Decodes one character under the selected dialect into a printer action.
// Purely combinational; depends on pcp_pkg.
module pcp_decode (
    input  logic [1:0]                  mode,
    input  logic [pcp_pkg::CHAR_W-1:0]  char_code,
    input  pcp_pkg::pcp_state_t         state,
    output pcp_pkg::pcp_state_t         state_next,
    output pcp_pkg::pcp_result_t        result
);

    logic ctrl;

    always_comb
    begin
        ctrl       = pcp_pkg::is_control(char_code);
        state_next = state;
        result     = '0;
        result.action = pcp_pkg::ACT_NONE;

        if (mode == pcp_pkg::MODE_DOT)
        begin
            if (state.escape)
            begin
                if (!state.underline_arg)
                begin
                    if (char_code == pcp_pkg::CH_UNDERLINE)
                    begin
                        state_next.underline_arg = 1'b1;
                    end
                    else
                    begin
                        result.unknown_code = 1'b1;
                        state_next.escape   = 1'b0;
                    end
                end
                else
                begin
                    // The underline argument is swallowed whatever it is.
                    state_next.underline_arg = 1'b0;
                    state_next.escape        = 1'b0;
                end
            end
            else if (ctrl)
            begin
                unique case (char_code) inside
                    pcp_pkg::CH_EXPAND:
                    begin
                        state_next.font     = pcp_pkg::FONT_EXPANDED;
                        result.action       = pcp_pkg::ACT_FONT;
                        result.font_changed = 1'b1;
                    end
                    pcp_pkg::CH_CANCEL_EX, pcp_pkg::CH_CANCEL_CD:
                    begin
                        state_next.font     = pcp_pkg::FONT_NORMAL;
                        result.action       = pcp_pkg::ACT_FONT;
                        result.font_changed = 1'b1;
                    end
                    pcp_pkg::CH_CONDENSE:
                    begin
                        state_next.font     = pcp_pkg::FONT_CONDENSED;
                        result.action       = pcp_pkg::ACT_FONT;
                        result.font_changed = 1'b1;
                    end
                    pcp_pkg::CH_CR:
                    begin
                        result.action = pcp_pkg::ACT_CR;
                    end
                    pcp_pkg::CH_LF:
                    begin
                        // One-line expansion ends at the line feed.
                        if (state.font == pcp_pkg::FONT_EXPANDED)
                        begin
                            state_next.font     = pcp_pkg::FONT_NORMAL;
                            result.font_changed = 1'b1;
                        end
                        result.action = pcp_pkg::ACT_LF;
                    end
                    pcp_pkg::CH_FF:
                    begin
                        result.action = pcp_pkg::ACT_PAGE;
                    end
                    pcp_pkg::CH_ESC:
                    begin
                        state_next.escape        = 1'b1;
                        state_next.underline_arg = 1'b0;
                    end
                    default:
                    begin
                        result.unknown_code = 1'b1;
                    end
                endcase
            end
            else
            begin
                result.action   = pcp_pkg::ACT_APPEND;
                result.out_char = char_code;
            end
        end
        else if (ctrl)
        begin
            if (char_code == pcp_pkg::CH_LF)
            begin
                result.action = (mode == pcp_pkg::MODE_CRLF) ? pcp_pkg::ACT_LF
                                                             : pcp_pkg::ACT_NEWLINE;
            end
            else if ((char_code == pcp_pkg::CH_CR) && (mode == pcp_pkg::MODE_CRLF))
            begin
                result.action = pcp_pkg::ACT_CR;
            end
            else if (char_code == pcp_pkg::CH_FF)
            begin
                result.action = pcp_pkg::ACT_PAGE;
            end
            else
            begin
                result.unknown_code = 1'b1;
            end
        end
        else
        begin
            result.action   = pcp_pkg::ACT_APPEND;
            result.out_char = char_code;
        end

        // The reported width is always the font state after this character.
        result.font_width = state_next.font;
    end

endmodule

### tb/printer_control_code_parser_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for printer_control_code_parser: a scoreboard class that
// decodes each accepted character on its own, and tasks and processes that drive every channel.
// Depends on pcp_pkg and the printer_control_code_parser RTL.

module printer_control_code_parser_test;

    typedef logic [pcp_pkg::CHAR_W-1:0] char_t;

    // The spare dialect code; the parser treats it as the simple dialect.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int PHASE_CHARS     = 125;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_SHOWN       = 40;

    // Scoreboard. It keeps its own copy of the dialect register and of the parser
    // state, decodes every character at the moment of its transfer into the block,
    // and queues the decoded result until the block delivers its own.
    class pcp_scoreboard;
        logic [1:0]            dialect;
        logic                  esc_seen;
        logic                  arg_wanted;
        logic [1:0]            width_code;
        pcp_pkg::pcp_result_t  awaited[$];
        int                    mismatches;

        function new();
            dialect    = pcp_pkg::MODE_SIMPLE;
            esc_seen   = 1'b0;
            arg_wanted = 1'b0;
            width_code = pcp_pkg::FONT_NORMAL;
            mismatches = 0;
        endfunction

        function void set_dialect(logic [1:0] value);
            dialect = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function bit clean();
            return (mismatches == 0) && (awaited.size() == 0);
        endfunction

        function bit control_char(char_t c);
            return (c <= pcp_pkg::CH_C0_LAST) ||
                   ((c >= pcp_pkg::CH_C1_FIRST) && (c <= pcp_pkg::CH_C1_LAST));
        endfunction

        // Decodes one character and advances the copied parser state.
        function pcp_pkg::pcp_result_t decode_char(char_t c);
            pcp_pkg::pcp_result_t r;
            r = '0;
            r.action = pcp_pkg::ACT_NONE;
            if (dialect == pcp_pkg::MODE_DOT)
            begin
                if (esc_seen)
                begin
                    if (!arg_wanted)
                    begin
                        if (c == pcp_pkg::CH_UNDERLINE)
                            arg_wanted = 1'b1;
                        else
                        begin
                            r.unknown_code = 1'b1;
                            esc_seen = 1'b0;
                        end
                    end
                    else
                    begin
                        // The underline argument is swallowed whatever it is.
                        arg_wanted = 1'b0;
                        esc_seen = 1'b0;
                    end
                end
                else if (control_char(c))
                begin
                    case (c)
                        pcp_pkg::CH_EXPAND:
                        begin
                            width_code = pcp_pkg::FONT_EXPANDED;
                            r.action = pcp_pkg::ACT_FONT;
                            r.font_changed = 1'b1;
                        end
                        pcp_pkg::CH_CANCEL_EX, pcp_pkg::CH_CANCEL_CD:
                        begin
                            width_code = pcp_pkg::FONT_NORMAL;
                            r.action = pcp_pkg::ACT_FONT;
                            r.font_changed = 1'b1;
                        end
                        pcp_pkg::CH_CONDENSE:
                        begin
                            width_code = pcp_pkg::FONT_CONDENSED;
                            r.action = pcp_pkg::ACT_FONT;
                            r.font_changed = 1'b1;
                        end
                        pcp_pkg::CH_CR: r.action = pcp_pkg::ACT_CR;
                        pcp_pkg::CH_LF:
                        begin
                            // Expanded print lasts for one line only.
                            if (width_code == pcp_pkg::FONT_EXPANDED)
                            begin
                                width_code = pcp_pkg::FONT_NORMAL;
                                r.font_changed = 1'b1;
                            end
                            r.action = pcp_pkg::ACT_LF;
                        end
                        pcp_pkg::CH_FF: r.action = pcp_pkg::ACT_PAGE;
                        pcp_pkg::CH_ESC:
                        begin
                            esc_seen = 1'b1;
                            arg_wanted = 1'b0;
                        end
                        default: r.unknown_code = 1'b1;
                    endcase
                end
                else
                begin
                    r.action = pcp_pkg::ACT_APPEND;
                    r.out_char = c;
                end
            end
            else if (control_char(c))
            begin
                if (c == pcp_pkg::CH_LF)
                    r.action = (dialect == pcp_pkg::MODE_CRLF) ? pcp_pkg::ACT_LF
                                                               : pcp_pkg::ACT_NEWLINE;
                else if ((c == pcp_pkg::CH_CR) && (dialect == pcp_pkg::MODE_CRLF))
                    r.action = pcp_pkg::ACT_CR;
                else if (c == pcp_pkg::CH_FF)
                    r.action = pcp_pkg::ACT_PAGE;
                else
                    r.unknown_code = 1'b1;
            end
            else
            begin
                r.action = pcp_pkg::ACT_APPEND;
                r.out_char = c;
            end
            r.font_width = width_code;
            return r;
        endfunction

        function void note_char(char_t c);
            awaited.push_back(decode_char(c));
        endfunction

        task report(string msg);
            if (mismatches < MAX_SHOWN)
                $display("%0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(pcp_pkg::pcp_result_t got);
            pcp_pkg::pcp_result_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("result with no character outstanding, action %0d",
                                 got.action));
                return;
            end
            want = awaited.pop_front();
            if (got.action !== want.action)
                report($sformatf("action: expected %0d, got %0d", want.action, got.action));
            if (got.out_char !== want.out_char)
                report($sformatf("out_char: expected %0h, got %0h",
                                 want.out_char, got.out_char));
            if (got.font_changed !== want.font_changed)
                report($sformatf("font_changed: expected %0b, got %0b",
                                 want.font_changed, got.font_changed));
            if (got.font_width !== want.font_width)
                report($sformatf("font_width: expected %0d, got %0d",
                                 want.font_width, got.font_width));
            if (got.unknown_code !== want.unknown_code)
                report($sformatf("unknown_code: expected %0b, got %0b",
                                 want.unknown_code, got.unknown_code));
        endtask
    endclass

    // Every input of the block starts at a known value.
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               char_valid = 1'b0;
    char_t              char_code = '0;
    logic               result_stall = 1'b0;
    logic               dialect_mode_we = 1'b0;
    logic [1:0]         dialect_mode_wdata = 2'd0;

    logic               char_stall;
    logic               result_valid;
    logic [2:0]         action;
    char_t              out_char;
    logic               font_changed;
    logic [1:0]         font_width;
    logic               unknown_code;

    pcp_scoreboard      sb;
    int                 cycle_count = 0;
    int                 stall_left = 0;
    bit                 steady = 1'b0;   // no idling on either side while set

    printer_control_code_parser DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .char_valid         (char_valid),
        .char_stall         (char_stall),
        .char_code          (char_code),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .action             (action),
        .out_char           (out_char),
        .font_changed       (font_changed),
        .font_width         (font_width),
        .unknown_code       (unknown_code),
        .dialect_mode_we    (dialect_mode_we),
        .dialect_mode_wdata (dialect_mode_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A hung handshake must not keep the run alive forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("printer_control_code_parser_test failed");
            $finish;
        end
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 2);
        else if (r < 94)
            return $urandom_range(3, 6);
        return $urandom_range(15, 40);
    endfunction

    // Result side back-pressure. Stall bursts draw their lengths from gap_len, so the
    // parser sees holds that fall on every stage of its pipeline, input and result register.
    always @(posedge clk)
    begin
        if (!rst_n || steady)
        begin
            stall_left = 0;
            result_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            result_stall <= 1'b1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left = gap_len();
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Result transfers are checked at the edge that completes them; the values
    // seen here are the ones held before the edge.
    always @(posedge clk)
    begin
        pcp_pkg::pcp_result_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got.action       = action;
            got.out_char     = out_char;
            got.font_changed = font_changed;
            got.font_width   = font_width;
            got.unknown_code = unknown_code;
            sb.check_result(got);
        end
    end

    // One character transfer. The task returns at the edge that takes the
    // character, so the valid stays high into the next call when no gap is drawn.
    task automatic send_char(input char_t c);
        int idle;
        idle = steady ? 0 : ($urandom_range(0, 1) ? 0 : gap_len());
        if (idle > 0)
        begin
            char_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_code  <= c;
        do
            @(posedge clk);
        while (char_stall);
        sb.note_char(c);
    endtask

    // Stops sending and waits until every queued result has come back, then waits
    // out SETTLE_CYCLES so that the block is idle before a register write.
    task automatic settle();
        char_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_dialect(input logic [1:0] value);
        dialect_mode_we    <= 1'b1;
        dialect_mode_wdata <= value;
        @(posedge clk);
        sb.set_dialect(value);
        dialect_mode_we    <= 1'b0;
    endtask

    // Random character: printable text, the codes with a meaning, the rest of the
    // control ranges, high code points and, now and then, any 21-bit value.
    function automatic char_t pick_char();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            return char_t'($urandom_range(32, 126));
        else if (sel < 55)
        begin
            case ($urandom_range(0, 7))
                0: return pcp_pkg::CH_LF;
                1: return pcp_pkg::CH_CR;
                2: return pcp_pkg::CH_FF;
                3: return pcp_pkg::CH_EXPAND;
                4: return pcp_pkg::CH_CONDENSE;
                5: return pcp_pkg::CH_CANCEL_CD;
                6: return pcp_pkg::CH_CANCEL_EX;
                default: return pcp_pkg::CH_ESC;
            endcase
        end
        else if (sel < 70)
            return char_t'($urandom_range(0, 31));
        else if (sel < 78)
            return char_t'($urandom_range(127, 159));
        else if (sel < 88)
            return char_t'($urandom_range(160, 21'h10FFFF));
        return char_t'($urandom());
    endfunction

    initial
    begin
        char_t             opening[$];
        logic [1:0]        phase_dialect[$];
        int                sent;
        int                sel;

        sb = new();

        // Directed opening in the dot-matrix dialect: append, each font code, the
        // one-line expansion ended by a line feed, a line feed in condensed print,
        // carriage return and form feed, a consumed underline argument at the top
        // of the code range, an unknown escape, the edges of both control ranges
        // and of the printable range, and codes above the Unicode range. It ends
        // expanded and inside an escape, so that the next dialect change shows
        // that this state is kept.
        opening = {21'h41, pcp_pkg::CH_EXPAND, pcp_pkg::CH_LF, pcp_pkg::CH_LF,
                   pcp_pkg::CH_CONDENSE, pcp_pkg::CH_LF, pcp_pkg::CH_CANCEL_EX,
                   pcp_pkg::CH_CONDENSE, pcp_pkg::CH_CANCEL_CD, pcp_pkg::CH_CR,
                   pcp_pkg::CH_FF, pcp_pkg::CH_ESC, pcp_pkg::CH_UNDERLINE,
                   21'h1FFFFF, pcp_pkg::CH_ESC, 21'h41, 21'h00, pcp_pkg::CH_C0_LAST,
                   pcp_pkg::CH_C1_FIRST, pcp_pkg::CH_C1_LAST, 21'h20, 21'hA0,
                   21'h10FFFF, 21'h110000, pcp_pkg::CH_EXPAND, pcp_pkg::CH_ESC};

        // Every dialect code, with the escape dialect visited most often.
        phase_dialect = {pcp_pkg::MODE_SIMPLE, pcp_pkg::MODE_CRLF, pcp_pkg::MODE_DOT,
                         MODE_SPARE, pcp_pkg::MODE_DOT, pcp_pkg::MODE_CRLF,
                         pcp_pkg::MODE_DOT, pcp_pkg::MODE_SIMPLE, pcp_pkg::MODE_DOT,
                         pcp_pkg::MODE_DOT};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_dialect(pcp_pkg::MODE_DOT);
        foreach (opening[i])
            send_char(opening[i]);
        settle();

        foreach (phase_dialect[p])
        begin
            write_dialect(phase_dialect[p]);
            steady = (p % 4 == 2);
            sent = 0;
            while (sent < PHASE_CHARS)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 2)
                begin
                    // A complete underline sequence with a random argument.
                    send_char(pcp_pkg::CH_ESC);
                    send_char(pcp_pkg::CH_UNDERLINE);
                    send_char(pick_char());
                    sent += 3;
                end
                else if (sel < 3)
                begin
                    // An escape followed by whatever comes.
                    send_char(pcp_pkg::CH_ESC);
                    send_char(pick_char());
                    sent += 2;
                end
                else
                begin
                    send_char(pick_char());
                    sent += 1;
                end
            end
            settle();
            steady = 1'b0;
        end

        if (sb.clean())
            $display("printer_control_code_parser_test passed");
        else
            $display("printer_control_code_parser_test failed");
        $finish;
    end

endmodule
